### design/four_vector_rotate_boost_defines.svh
// ---------------------------------------------------------------------------
// Four-vector rotate/boost assertion macros
// Shared macros for the concurrent assertions of the block.
// ---------------------------------------------------------------------------
`ifndef FOUR_VECTOR_ROTATE_BOOST_DEFINES_SVH
`define FOUR_VECTOR_ROTATE_BOOST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FVRB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define FVRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/fvrb_pkg.sv
// ---------------------------------------------------------------------------
// Four-vector rotate/boost package
// Widths, mode codes and the item type shared by the block's modules.
// ---------------------------------------------------------------------------
`default_nettype none

package fvrb_pkg;

    localparam int COMP_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_WIDTH = 18;

    // Radicand and divider datapath width.
    localparam int SQ_W     = 64;
    localparam int SQ_STEPS = 32;
    // Radicand pre-shift is two times this.
    localparam int K_SHIFT  = 31 - FRAC_BITS;
    // Gamma quotient width, covers the largest gamma for |beta| just below one.
    localparam int Q_W      = (3 * FRAC_BITS + 1) / 2 + 1;
    // Signed coefficient width: holds gamma, gamma*beta and a negated cosine.
    localparam int CF_W     = Q_W + 2;
    localparam int PROD_W   = COMP_WIDTH + CF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int SH_W     = SUM_W - FRAC_BITS;

    // Gamma unit latency: radicand register, root steps, divide steps.
    localparam int GAM_LAT  = 1 + SQ_STEPS + Q_W;
    // Whole pipeline: gamma, gamma*beta, select, multiply, sum, clip.
    localparam int LAT      = GAM_LAT + 5;

    localparam logic [2:0] MODE_ROT_X   = 3'd0;
    localparam logic [2:0] MODE_ROT_Y   = 3'd1;
    localparam logic [2:0] MODE_ROT_Z   = 3'd2;
    localparam logic [2:0] MODE_BOOST_X = 3'd3;
    localparam logic [2:0] MODE_BOOST_Y = 3'd4;
    localparam logic [2:0] MODE_BOOST_Z = 3'd5;

    localparam logic [1:0] IDX_T = 2'd0;
    localparam logic [1:0] IDX_X = 2'd1;
    localparam logic [1:0] IDX_Y = 2'd2;
    localparam logic [1:0] IDX_Z = 2'd3;

    typedef logic signed [COMP_WIDTH-1:0] t_comp;
    typedef logic signed [COEF_WIDTH-1:0] t_coef;
    typedef logic signed [CF_W-1:0]       t_wcoef;

    typedef struct packed {
        logic [2:0] mode;
        t_comp      t;
        t_comp      x;
        t_comp      y;
        t_comp      z;
        t_coef      cs;
        t_coef      sn;
        t_coef      b;
    } t_item;

    // One output component: round((opa*ca - opb*cb) / 2^F) written at idx.
    typedef struct packed {
        t_comp      opa;
        t_comp      opb;
        t_wcoef     ca;
        t_wcoef     cb;
        logic [1:0] idx;
    } t_lane;

endpackage

`default_nettype wire

### design/fvrb_gamma.sv
// ---------------------------------------------------------------------------
// Lorentz factor unit
// Pipelined gamma = 1/sqrt(1-beta^2): one root bit and one quotient bit per
// register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module fvrb_gamma (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire fvrb_pkg::t_coef       i_beta,
    output logic [fvrb_pkg::Q_W-1:0]   o_gamma
);
    import fvrb_pkg::*;

    logic [COEF_WIDTH-1:0]  ab;
    logic [FRAC_BITS-1:0]   ab_low;
    logic [2*FRAC_BITS:0]   d;

    logic [SQ_W-1:0] r_sv [0:SQ_STEPS];
    logic [SQ_W-1:0] r_sr [0:SQ_STEPS];
    logic [SQ_W-1:0] n_sv [1:SQ_STEPS];
    logic [SQ_W-1:0] n_sr [1:SQ_STEPS];

    logic [SQ_W-1:0] r_dr [1:Q_W];
    logic [31:0]     r_dd [1:Q_W];
    logic [Q_W-1:0]  r_dq [1:Q_W];
    logic [SQ_W-1:0] n_dr [1:Q_W];
    logic [Q_W-1:0]  n_dq [1:Q_W];

    logic [31:0]     rt1;
    logic [SQ_W-1:0] num0;

    // Radicand (1 - beta^2) scaled so the root lands on 31 fraction bits.
    always_comb begin
        ab     = i_beta[COEF_WIDTH-1] ? COEF_WIDTH'(-i_beta) : COEF_WIDTH'(i_beta);
        ab_low = ab[FRAC_BITS-1:0];
        d      = ((2*FRAC_BITS+1)'(1) << (2*FRAC_BITS))
                 - ((2*FRAC_BITS+1)'(ab_low) * (2*FRAC_BITS+1)'(ab_low));
    end

    always_comb begin
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] sumv;
        for (int i = 0; i < SQ_STEPS; i++) begin
            bitv = SQ_W'(1) << (2*SQ_STEPS - 2 - 2*i);
            sumv = r_sr[i] + bitv;
            if (r_sv[i] >= sumv) begin
                n_sv[i+1] = r_sv[i] - sumv;
                n_sr[i+1] = (r_sr[i] >> 1) + bitv;
            end else begin
                n_sv[i+1] = r_sv[i];
                n_sr[i+1] = r_sr[i] >> 1;
            end
        end
    end

    // A zero root cannot occur for a valid beta; it is forced to one anyway.
    assign rt1  = (r_sr[SQ_STEPS] == '0) ? 32'd1 : r_sr[SQ_STEPS][31:0];
    assign num0 = (SQ_W'(1) << (2*FRAC_BITS + K_SHIFT)) + SQ_W'(rt1 >> 1);

    always_comb begin
        logic [SQ_W-1:0] rem;
        logic [31:0]     dv;
        logic [Q_W-1:0]  q;
        logic [SQ_W-1:0] shd;
        for (int k = 0; k < Q_W; k++) begin
            rem = (k == 0) ? num0 : r_dr[k];
            dv  = (k == 0) ? rt1  : r_dd[k];
            q   = (k == 0) ? '0   : r_dq[k];
            shd = SQ_W'(dv) << (Q_W - 1 - k);
            if (rem >= shd) begin
                n_dr[k+1] = rem - shd;
                q[Q_W-1-k] = 1'b1;
            end else begin
                n_dr[k+1] = rem;
            end
            n_dq[k+1] = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sv[0] <= SQ_W'(d) << (2*K_SHIFT);
            r_sr[0] <= '0;
            for (int i = 1; i <= SQ_STEPS; i++) begin
                r_sv[i] <= n_sv[i];
                r_sr[i] <= n_sr[i];
            end
            r_dd[1] <= rt1;
            for (int k = 2; k <= Q_W; k++) begin
                r_dd[k] <= r_dd[k-1];
            end
            for (int k = 1; k <= Q_W; k++) begin
                r_dr[k] <= n_dr[k];
                r_dq[k] <= n_dq[k];
            end
        end
    end

    assign o_gamma = r_dq[Q_W];

endmodule

`default_nettype wire

### design/four_vector_rotate_boost.sv
// ---------------------------------------------------------------------------
// Four-vector rotate and boost
// Rotates (t,x,y,z) about an axis or applies a Lorentz boost along it, in
// signed Q15.16, with rounding, saturation and a beta range flag.
// ---------------------------------------------------------------------------
//  Channel   Direction   Handshake                  Payload
//  in        to block    i_in_valid / o_in_ready    mode, four components, cos, sin, beta
//  out       from block  o_out_valid / i_out_ready  four components, saturated, beta_error
//
//  One item is taken in every cycle unless a result waits at the output.
//  The gamma unit has a radicand register, 32 square-root steps and 25 divide
//  steps, each one register stage; then come five stages of multiply and clip.
//  Reset clears only the valid bits of the pipeline.
//  When a result waits at the output, the whole pipeline holds; nothing moves,
//  so nothing is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module four_vector_rotate_boost (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [2:0]        i_mode,
    input  wire fvrb_pkg::t_comp   i_comp_t,
    input  wire fvrb_pkg::t_comp   i_comp_x,
    input  wire fvrb_pkg::t_comp   i_comp_y,
    input  wire fvrb_pkg::t_comp   i_comp_z,
    input  wire fvrb_pkg::t_coef   i_cos_angle,
    input  wire fvrb_pkg::t_coef   i_sin_angle,
    input  wire fvrb_pkg::t_coef   i_beta,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output fvrb_pkg::t_comp        o_out_t,
    output fvrb_pkg::t_comp        o_out_x,
    output fvrb_pkg::t_comp        o_out_y,
    output fvrb_pkg::t_comp        o_out_z,
    output logic                   o_saturated,
    output logic                   o_beta_error
);
    import fvrb_pkg::*;

    localparam t_comp CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam t_comp CMIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    logic en;
    logic [1:LAT] r_vld;
    t_item r_item [1:GAM_LAT];
    logic [Q_W-1:0] gamma;

    // gamma*|beta| stage
    t_item          r_gitem;
    logic [Q_W-1:0] r_g;
    logic [Q_W-1:0] r_gbm;

    // select stage
    t_lane r_sel_lane [0:1];
    logic  r_sel_act;
    logic  r_sel_berr;
    t_comp r_sel_vec [0:3];

    // multiply stage
    logic signed [PROD_W-1:0] r_pa [0:1];
    logic signed [PROD_W-1:0] r_pb [0:1];
    logic [1:0] r_mul_idx [0:1];
    logic  r_mul_act;
    logic  r_mul_berr;
    t_comp r_mul_vec [0:3];

    // sum stage
    logic signed [SH_W-1:0] r_sum [0:1];
    logic [1:0] r_sum_idx [0:1];
    logic  r_sum_act;
    logic  r_sum_berr;
    t_comp r_sum_vec [0:3];

    // output
    t_comp r_out_vec [0:3];
    logic  r_out_sat;
    logic  r_out_berr;

    t_item n_in;
    logic [Q_W+FRAC_BITS-1:0] gprod;
    t_lane n_lane [0:1];
    logic  n_act;
    logic  n_berr;
    t_comp n_vec [0:3];
    t_comp n_out [0:3];
    logic  n_sat;

    assign en         = !r_vld[LAT] || i_out_ready;
    assign o_in_ready = en;

    assign n_in = '{mode: i_mode, t: i_comp_t, x: i_comp_x, y: i_comp_y, z: i_comp_z,
                    cs: i_cos_angle, sn: i_sin_angle, b: i_beta};

    fvrb_gamma u_gamma (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_beta  (i_beta),
        .o_gamma (gamma)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {i_in_valid, r_vld[1:LAT-1]};
        end
    end

    assign gprod = Q_W'(gamma) *
                   (Q_W+FRAC_BITS)'(r_item[GAM_LAT].b[COEF_WIDTH-1] ?
                        COEF_WIDTH'(-r_item[GAM_LAT].b) : COEF_WIDTH'(r_item[GAM_LAT].b));

    // Lane setup: each lane forms one component from two products.
    always_comb begin
        logic [COEF_WIDTH-1:0] ab;
        t_wcoef wcs;
        t_wcoef wsn;
        t_wcoef wg;
        t_wcoef wgb;
        logic [1:0] ax;
        ab     = r_gitem.b[COEF_WIDTH-1] ? COEF_WIDTH'(-r_gitem.b) : COEF_WIDTH'(r_gitem.b);
        wcs    = CF_W'(r_gitem.cs);
        wsn    = CF_W'(r_gitem.sn);
        wg     = $signed({2'b00, r_g});
        wgb    = r_gitem.b[COEF_WIDTH-1] ? -$signed({2'b00, r_gbm}) : $signed({2'b00, r_gbm});
        n_vec  = '{r_gitem.t, r_gitem.x, r_gitem.y, r_gitem.z};
        n_act  = 1'b0;
        n_berr = 1'b0;
        ax     = IDX_X;
        for (int l = 0; l < 2; l++) begin
            n_lane[l] = '0;
        end
        case (r_gitem.mode)
            MODE_ROT_X, MODE_ROT_Y, MODE_ROT_Z: begin
                n_act = 1'b1;
                case (r_gitem.mode)
                    MODE_ROT_X: begin
                        n_lane[0] = '{r_gitem.y, r_gitem.z, wcs, wsn, IDX_Y};
                        n_lane[1] = '{r_gitem.y, r_gitem.z, wsn, -wcs, IDX_Z};
                    end
                    MODE_ROT_Y: begin
                        n_lane[0] = '{r_gitem.z, r_gitem.x, wcs, wsn, IDX_Z};
                        n_lane[1] = '{r_gitem.z, r_gitem.x, wsn, -wcs, IDX_X};
                    end
                    default: begin
                        n_lane[0] = '{r_gitem.x, r_gitem.y, wcs, wsn, IDX_X};
                        n_lane[1] = '{r_gitem.x, r_gitem.y, wsn, -wcs, IDX_Y};
                    end
                endcase
            end
            MODE_BOOST_X, MODE_BOOST_Y, MODE_BOOST_Z: begin
                case (r_gitem.mode)
                    MODE_BOOST_X: ax = IDX_X;
                    MODE_BOOST_Y: ax = IDX_Y;
                    default:      ax = IDX_Z;
                endcase
                n_berr    = ab >= COEF_WIDTH'(1 << FRAC_BITS);
                n_act     = !n_berr;
                n_lane[0] = '{n_vec[ax], r_gitem.t, wg, wgb, ax};
                n_lane[1] = '{r_gitem.t, n_vec[ax], wg, wgb, IDX_T};
            end
            default: begin
                n_act = 1'b0;
            end
        endcase
    end

    // Clip the two lane results and, for an active item, write them over the passed vector.
    always_comb begin
        t_comp c;
        n_out = r_sum_vec;
        n_sat = 1'b0;
        for (int l = 0; l < 2; l++) begin
            if (r_sum[l] > SH_W'(CMAX)) begin
                c = CMAX;
                n_sat = n_sat | r_sum_act;
            end else if (r_sum[l] < SH_W'(CMIN)) begin
                c = CMIN;
                n_sat = n_sat | r_sum_act;
            end else begin
                c = COMP_WIDTH'(r_sum[l]);
            end
            if (r_sum_act) begin
                n_out[r_sum_idx[l]] = c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item[1] <= n_in;
            for (int s = 2; s <= GAM_LAT; s++) begin
                r_item[s] <= r_item[s-1];
            end

            r_gitem <= r_item[GAM_LAT];
            r_g     <= gamma;
            r_gbm   <= Q_W'((gprod + (Q_W+FRAC_BITS)'(1 << (FRAC_BITS-1))) >> FRAC_BITS);

            r_sel_lane <= n_lane;
            r_sel_act  <= n_act;
            r_sel_berr <= n_berr;
            r_sel_vec  <= n_vec;

            for (int l = 0; l < 2; l++) begin
                r_pa[l]      <= PROD_W'(r_sel_lane[l].opa) * PROD_W'(r_sel_lane[l].ca);
                r_pb[l]      <= PROD_W'(r_sel_lane[l].opb) * PROD_W'(r_sel_lane[l].cb);
                r_mul_idx[l] <= r_sel_lane[l].idx;
            end
            r_mul_act  <= r_sel_act;
            r_mul_berr <= r_sel_berr;
            r_mul_vec  <= r_sel_vec;

            for (int l = 0; l < 2; l++) begin
                r_sum[l] <= SH_W'((SUM_W'(r_pa[l]) - SUM_W'(r_pb[l])
                                   + SUM_W'(1 << (FRAC_BITS-1))) >>> FRAC_BITS);
                r_sum_idx[l] <= r_mul_idx[l];
            end
            r_sum_act  <= r_mul_act;
            r_sum_berr <= r_mul_berr;
            r_sum_vec  <= r_mul_vec;

            r_out_vec  <= n_out;
            r_out_sat  <= n_sat;
            r_out_berr <= r_sum_berr;
        end
    end

    assign o_out_valid  = r_vld[LAT];
    assign o_out_t      = r_out_vec[0];
    assign o_out_x      = r_out_vec[1];
    assign o_out_y      = r_out_vec[2];
    assign o_out_z      = r_out_vec[3];
    assign o_saturated  = r_out_sat;
    assign o_beta_error = r_out_berr;

endmodule

`default_nettype wire

### design/fvrb_checker.sv
// ---------------------------------------------------------------------------
// Four-vector rotate/boost port checker
// Watches the top level's ports over time; bound to every instance.
// ---------------------------------------------------------------------------
`default_nettype none
`include "four_vector_rotate_boost_defines.svh"

module fvrb_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              o_in_ready,
    input  wire logic [2:0]        i_mode,
    input  wire fvrb_pkg::t_comp   i_comp_t,
    input  wire fvrb_pkg::t_comp   i_comp_x,
    input  wire fvrb_pkg::t_comp   i_comp_y,
    input  wire fvrb_pkg::t_comp   i_comp_z,
    input  wire fvrb_pkg::t_coef   i_cos_angle,
    input  wire fvrb_pkg::t_coef   i_sin_angle,
    input  wire fvrb_pkg::t_coef   i_beta,
    input  wire logic              o_out_valid,
    input  wire logic              i_out_ready,
    input  wire fvrb_pkg::t_comp   o_out_t,
    input  wire fvrb_pkg::t_comp   o_out_x,
    input  wire fvrb_pkg::t_comp   o_out_y,
    input  wire fvrb_pkg::t_comp   o_out_z,
    input  wire logic              o_saturated,
    input  wire logic              o_beta_error
);
    import fvrb_pkg::*;

    // A beta range error passes the vector, so nothing can have clipped.
    `FVRB_ASSERT_IMPL(a_berr_no_sat, i_clk, i_rst_n, o_out_valid && o_beta_error, !o_saturated)

    // The input side only stalls behind a result that is not taken.
    `FVRB_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

    // The pipeline is empty right after reset.
    `FVRB_ASSERT_IMPL(a_empty_after_rst, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)

    // A result that is not taken stays offered.
    `FVRB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

endmodule

bind four_vector_rotate_boost fvrb_checker u_fvrb_checker (.*);

`default_nettype wire
